// ===== hdl/psrch_pkg.sv =====
// Shared types and constants of the stream pattern search block.
// No dependencies; used by every other file in hdl/.
package psrch_pkg;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int OFFSET_W = 32;
  localparam int INDEX_W  = 6;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Request type codes
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_STREAM  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 1'b1;

  // Window control: shift in one stream byte, optionally close the search
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } win_ctrl_t;

  // Pattern store write request
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;
  } pat_wr_t;

endpackage

// ===== hdl/psrch_pattern_store.sv =====
// Pattern byte store: one flop byte per pattern position, written by index.
// Depends on psrch_pkg.
module psrch_pattern_store #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                                   clk,
  input  psrch_pkg::pat_wr_t                     wr,
  output logic [MAX_PATTERN*psrch_pkg::BYTE_W-1:0] pattern_vec
);

  logic [psrch_pkg::BYTE_W-1:0] store [MAX_PATTERN];

  // Write the addressed entry; indexes past the store are dropped
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (wr.en && (int'(wr.index) == j)) begin
        store[j] <= wr.data;
      end
    end
  end

  // Present entry j at byte lane j
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pattern_vec[j*psrch_pkg::BYTE_W +: psrch_pkg::BYTE_W] = store[j];
    end
  end

endmodule

// ===== hdl/psrch_window.sv =====
// Stream byte window with oldest byte at lane 0 and newest at the top lane,
// plus a barrel shifter that lines up the newest bytes with the pattern.
// Depends on psrch_pkg.
module psrch_window #(
  parameter int MAX_PATTERN = 64,
  parameter int SH_W        = 7
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  psrch_pkg::win_ctrl_t                     ctrl,
  input  logic [SH_W-1:0]                          align_shift,
  output logic [MAX_PATTERN*psrch_pkg::BYTE_W-1:0] aligned_vec
);

  localparam int WIN_W = MAX_PATTERN * psrch_pkg::BYTE_W;

  logic [WIN_W-1:0] window;
  logic [WIN_W-1:0] window_next;

  // Drop the oldest byte, append the new one at the top lane
  always_comb begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      window_next[i*psrch_pkg::BYTE_W +: psrch_pkg::BYTE_W] =
        window[(i+1)*psrch_pkg::BYTE_W +: psrch_pkg::BYTE_W];
    end
    window_next[(MAX_PATTERN-1)*psrch_pkg::BYTE_W +: psrch_pkg::BYTE_W] = ctrl.data;
  end

  // Advance on each stream byte; empty the window when a search closes
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      window <= '0;
    end else if (ctrl.shift) begin
      window <= window_next;
    end
  end

  // Bring the newest pattern_length bytes down to lanes 0 and up
  assign aligned_vec = window_next >> {align_shift, 3'b000};

endmodule

// ===== hdl/stream_pattern_search_top.sv =====
// Top level of the stream pattern search block: input register, search
// control, window compare and result register.
// Depends on psrch_pkg, psrch_pattern_store and psrch_window.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per transfer:
//   req_type REQ_PATTERN writes data_byte to pattern entry pattern_index,
//   req_type REQ_STREAM presents one stream byte, with last closing the
//   search. The result channel (out_valid/out_ready) returns found and
//   match_offset once per search: on the first match, or on the last byte
//   when nothing matched. The configuration channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes pattern_length (index 0) and start_offset
//   (index 1); it is always ready and must be written while the block is idle;
//   the block does not enforce this. A request is held in the input register
//   and its result is registered. Throughput: one request per cycle while
//   the receiver does not stall. The cycle holds the window barrel shift
//   and a parallel compare of MAX_PATTERN byte lanes.
//   Reset empties the window, zeroes the byte count and search flag, sets
//   pattern_length to 1 and start_offset to 0; the pattern store holds
//   whatever it had. While the receiver stalls with a result pending, the
//   input register fills and then in_ready drops.
module stream_pattern_search_top #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [psrch_pkg::BYTE_W-1:0]        data_byte,
  input  logic [psrch_pkg::INDEX_W-1:0]       pattern_index,
  input  logic                                last,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                found,
  output logic [psrch_pkg::OFFSET_W-1:0]      match_offset,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psrch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psrch_pkg::CFG_W-1:0]         cfg_data
);

  localparam int SH_W  = $clog2(MAX_PATTERN + 1);
  localparam int WIN_W = MAX_PATTERN * psrch_pkg::BYTE_W;

  // configuration registers
  logic [psrch_pkg::LEN_W-1:0]    pattern_length;
  logic [psrch_pkg::OFFSET_W-1:0] start_offset;

  // input register
  logic                           s_valid;
  logic                           s_req;
  logic [psrch_pkg::BYTE_W-1:0]   s_data;
  logic [psrch_pkg::INDEX_W-1:0]  s_index;
  logic                           s_last;

  // search state
  logic [psrch_pkg::OFFSET_W-1:0] bytes_seen;
  logic [psrch_pkg::OFFSET_W-1:0] bytes_seen_next;
  logic                           match_done;

  logic                           advance;
  logic                           stream_step;
  logic                           len_ok;
  logic [SH_W-1:0]                align_shift;
  logic [WIN_W-1:0]               aligned_vec;
  logic [WIN_W-1:0]               pattern_vec;
  logic [MAX_PATTERN-1:0]         lane_ok;
  logic                           hit;
  logic                           emit;
  psrch_pkg::win_ctrl_t           win_ctrl;
  psrch_pkg::pat_wr_t             pat_wr;

  // Evaluate the held request when the result register can take a result
  assign advance     = s_valid && (!out_valid || out_ready);
  assign stream_step = advance && (s_req == psrch_pkg::REQ_STREAM);
  assign in_ready    = !s_valid || advance;
  assign cfg_ready   = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= psrch_pkg::LEN_W'(1);
      start_offset   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psrch_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[psrch_pkg::LEN_W-1:0];
        psrch_pkg::CFG_START_OFFSET:   start_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture a request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_req   <= req_type;
      s_data  <= data_byte;
      s_index <= pattern_index;
      s_last  <= last;
    end
  end

  // Pattern store and stream window
  assign pat_wr.en    = advance && (s_req == psrch_pkg::REQ_PATTERN);
  assign pat_wr.index = s_index;
  assign pat_wr.data  = s_data;

  assign win_ctrl.shift = stream_step;
  assign win_ctrl.clear = stream_step && s_last;
  assign win_ctrl.data  = s_data;

  psrch_pattern_store #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_store (
    .clk         (clk),
    .wr          (pat_wr),
    .pattern_vec (pattern_vec)
  );

  psrch_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .SH_W        (SH_W)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (win_ctrl),
    .align_shift (align_shift),
    .aligned_vec (aligned_vec)
  );

  // Saturating byte count including the byte being evaluated
  assign bytes_seen_next = (&bytes_seen) ? bytes_seen : bytes_seen + psrch_pkg::OFFSET_W'(1);

  // Window compare over the newest pattern_length bytes
  assign len_ok      = (pattern_length != '0) && (int'(pattern_length) <= MAX_PATTERN);
  assign align_shift = SH_W'(MAX_PATTERN) - SH_W'(pattern_length);

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      lane_ok[j] = (j >= int'(pattern_length)) ||
                   (aligned_vec[j*psrch_pkg::BYTE_W +: psrch_pkg::BYTE_W] ==
                    pattern_vec[j*psrch_pkg::BYTE_W +: psrch_pkg::BYTE_W]);
    end
  end

  assign hit  = len_ok && (bytes_seen_next >= psrch_pkg::OFFSET_W'(pattern_length)) && (&lane_ok);
  assign emit = stream_step && !match_done && (hit || s_last);

  // Search state: count, first-match flag, cleared by the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_done <= 1'b0;
    end else if (stream_step) begin
      if (s_last) begin
        bytes_seen <= '0;
        match_done <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        if (hit) begin
          match_done <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found        <= hit;
      match_offset <= hit ? start_offset + (bytes_seen_next -
                            psrch_pkg::OFFSET_W'(pattern_length))
                          : '0;
    end
  end

  // A pending result is never overwritten by a new one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !emit)
    else $error("result overwritten while stalled");

  // A match inside a search arms the first-match flag
  assert property (@(posedge clk) disable iff (rst)
    emit && hit && !s_last |=> match_done)
    else $error("match flag not set after match");

  // No result once the search has matched
  assert property (@(posedge clk) disable iff (rst)
    match_done && stream_step |-> !emit)
    else $error("second result in one search");

  // The last byte leaves a fresh search behind
  assert property (@(posedge clk) disable iff (rst)
    stream_step && s_last |=> (bytes_seen == '0) && !match_done)
    else $error("search state not cleared by last byte");

endmodule
